// ===== hdl/bsfe_pkg.sv =====
package bsfe_pkg;

    localparam logic [7:0]  LINE_DELIM = 8'h7E;
    localparam logic [7:0]  LINE_ESC   = 8'h7D;
    localparam logic [7:0]  ESC_FLIP   = 8'h20;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam int          MAX_RUN    = 8;
    localparam int          RUN_CNT_W  = $clog2(MAX_RUN + 1);
    localparam int          RUN_IDX_W  = $clog2(MAX_RUN);

    typedef struct packed {
        logic [7:0] line_byte;
        logic       done;
    } line_item_t;

    typedef struct packed {
        logic [15:0] crc;
        logic [31:0] sum;
    } csum_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] sum_fold(input logic [31:0] sum);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, sum[31:16]} + {1'b0, sum[15:0]};
        s2 = {1'b0, s1[15:0]} + {16'h0000, s1[16]};
        return ~s2[15:0];
    endfunction

endpackage

// ===== hdl/bsfe_if.sv =====
interface bsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface bsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       run_end;
    logic       frame_done;

    modport source (output valid, output line_byte, output run_end, output frame_done,
                    input ready);
    modport sink   (input valid, input line_byte, input run_end, input frame_done,
                    output ready);
endinterface

// ===== hdl/byte_stuffed_frame_encoder.sv =====
// Byte-stuffing frame encoder. Each accepted word is one unstuffed frame byte;
// the block emits 0x7E before the first byte of a frame, escapes 0x7D/0x7E as
// 0x7D, byte^0x20, and after the word flagged frame_end sends the stuffed
// 16-bit checksum (CRC-16 0x1021 or folded ones-complement word sum, chosen by
// cfg_wr_data when cfg_wr_en is high) and a closing 0x7E with frame_done set.
// One input word yields 1 to 8 line words (1 for a plain mid-frame byte, up to
// 8 for a single-byte frame); the output side sends one line word per cycle
// while out_word.ready is high, so input words are taken only as fast as their
// line words are sent. An accepted word passes through one input stage, then
// the run register that feeds the output. A staged input word moves into the
// run register when it is empty or in the cycle the last line word of the
// run before it is sent, and the next input word is taken in that same cycle,
// so runs follow each other with no gap.
module byte_stuffed_frame_encoder
    import bsfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bsfe_in_if.sink    in_word,
    bsfe_out_if.source out_word,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data
);

    logic                 mode_reg;
    logic                 in_frame_reg;

    logic                 p_valid_reg;
    logic [7:0]           p_byte_reg;
    logic                 p_last_reg;
    logic                 p_open_reg;
    logic                 p_mode_reg;
    csum_t                p_csum_reg;

    line_item_t           run_reg [MAX_RUN];
    logic [RUN_CNT_W-1:0] cnt_reg;

    csum_t                csum;
    logic                 accept;
    logic                 take;
    logic                 load;

    line_item_t           run_next [MAX_RUN];
    logic [RUN_CNT_W-1:0] cnt_next;
    logic [15:0]          check;
    logic [7:0]           src [3];

    bsfe_csum u_csum
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .frame_byte (in_word.frame_byte),
        .frame_end  (in_word.frame_end),
        .csum       (csum)
    );

    assign take   = out_word.valid && out_word.ready;
    assign load   = p_valid_reg &&
                    ((cnt_reg == '0) || ((cnt_reg == RUN_CNT_W'(1)) && out_word.ready));
    assign in_word.ready = !p_valid_reg || load;
    assign accept = in_word.valid && in_word.ready;

    assign out_word.valid      = (cnt_reg != '0);
    assign out_word.line_byte  = run_reg[0].line_byte;
    assign out_word.frame_done = run_reg[0].done;
    assign out_word.run_end    = (cnt_reg == RUN_CNT_W'(1));

    // build the run of line words for the staged byte
    always_comb
    begin
        check  = p_mode_reg ? sum_fold(p_csum_reg.sum) : p_csum_reg.crc;
        src[0] = p_byte_reg;
        src[1] = check[15:8];
        src[2] = check[7:0];
        cnt_next = '0;
        for (int i = 0; i < MAX_RUN; i++)
        begin
            run_next[i] = '{line_byte: LINE_DELIM, done: 1'b0};
        end
        if (p_open_reg)
        begin
            run_next[cnt_next[RUN_IDX_W-1:0]] = '{line_byte: LINE_DELIM, done: 1'b0};
            cnt_next = cnt_next + RUN_CNT_W'(1);
        end
        for (int k = 0; k < 3; k++)
        begin
            if (k == 0 || p_last_reg)
            begin
                if (src[k] == LINE_ESC || src[k] == LINE_DELIM)
                begin
                    run_next[cnt_next[RUN_IDX_W-1:0]] = '{line_byte: LINE_ESC, done: 1'b0};
                    cnt_next = cnt_next + RUN_CNT_W'(1);
                    run_next[cnt_next[RUN_IDX_W-1:0]] =
                        '{line_byte: src[k] ^ ESC_FLIP, done: 1'b0};
                    cnt_next = cnt_next + RUN_CNT_W'(1);
                end
                else
                begin
                    run_next[cnt_next[RUN_IDX_W-1:0]] = '{line_byte: src[k], done: 1'b0};
                    cnt_next = cnt_next + RUN_CNT_W'(1);
                end
            end
        end
        if (p_last_reg)
        begin
            run_next[cnt_next[RUN_IDX_W-1:0]] = '{line_byte: LINE_DELIM, done: 1'b1};
            cnt_next = cnt_next + RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            in_frame_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (accept)
            begin
                in_frame_reg <= !in_word.frame_end;
                p_valid_reg  <= 1'b1;
            end
            else if (load)
                p_valid_reg <= 1'b0;
            if (load)
                cnt_reg <= cnt_next;
            else if (take)
                cnt_reg <= cnt_reg - RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_byte_reg <= in_word.frame_byte;
            p_last_reg <= in_word.frame_end;
            p_open_reg <= !in_frame_reg;
            p_mode_reg <= mode_reg;
            p_csum_reg <= csum;
        end
        if (load)
            run_reg <= run_next;
        else if (take)
        begin
            for (int i = 0; i < MAX_RUN - 1; i++)
            begin
                run_reg[i] <= run_reg[i+1];
            end
        end
    end

endmodule

// ===== hdl/bsfe_csum.sv =====
module bsfe_csum
    import bsfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    output csum_t      csum
);

    logic [15:0] crc_reg;
    logic [31:0] sum_reg;
    logic [7:0]  held_reg;
    logic        odd_reg;

    logic [15:0] crc_next;
    logic [31:0] sum_next;

    // word sum including this byte; odd final byte goes in unshifted
    always_comb
    begin
        crc_next = crc_update(crc_reg, frame_byte);
        if (odd_reg)
            sum_next = sum_reg + {16'h0000, held_reg, frame_byte};
        else
            sum_next = sum_reg + {24'h000000, frame_byte};
    end

    assign csum.crc = crc_next;
    assign csum.sum = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= '0;
            sum_reg  <= '0;
            held_reg <= '0;
            odd_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (frame_end)
            begin
                crc_reg  <= '0;
                sum_reg  <= '0;
                held_reg <= '0;
                odd_reg  <= 1'b0;
            end
            else if (odd_reg)
            begin
                crc_reg <= crc_next;
                sum_reg <= sum_next;
                odd_reg <= 1'b0;
            end
            else
            begin
                crc_reg  <= crc_next;
                held_reg <= frame_byte;
                odd_reg  <= 1'b1;
            end
        end
    end

endmodule

// ===== hdl/bsfe_checker.sv =====
module bsfe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] line_byte,
    input logic       run_end,
    input logic       frame_done
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_byte))
        else $error("line word changed while stalled");

    // closing delimiter is always 0x7E and ends its run
    a_done_delim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> line_byte == 8'h7E && run_end)
        else $error("frame_done on a non-delimiter or mid-run word");

    // an escape never ends a run or a frame, so its flipped byte follows in the same run
    a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_byte == 8'h7D |-> !run_end && !frame_done)
        else $error("escape ends a run");

    // opening delimiter never ends a run
    a_open_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_byte == 8'h7E && !frame_done |-> !run_end)
        else $error("opening delimiter ends a run");

    // escape is followed by a flipped special byte
    a_esc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && line_byte == 8'h7D |=>
        out_valid && (line_byte == 8'h5D || line_byte == 8'h5E))
        else $error("escape not followed by flipped byte");

endmodule

bind byte_stuffed_frame_encoder bsfe_checker u_bsfe_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_word.valid),
    .out_ready  (out_word.ready),
    .line_byte  (out_word.line_byte),
    .run_end    (out_word.run_end),
    .frame_done (out_word.frame_done)
);
